// File: rtl/core/olae_pkg.sv
`default_nettype none

package olae_pkg;

  localparam int CAPACITY     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int KEY_W        = 64;
  localparam int ITEM_PAY_W   = 32;
  localparam int POS_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_NOKEY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LOWER,
    CELL_TAKE_UPPER
  } cell_op_e;

  typedef struct packed {
    logic [2:0]            cmd;
    logic                  at_end;
    logic [POS_W-1:0]      position;
    logic [KEY_W-1:0]      item_key;
    logic [ITEM_PAY_W-1:0] item_payload;
  } item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [POS_W-1:0]      found_position;
    logic [KEY_W-1:0]      entry_key;
    logic [ITEM_PAY_W-1:0] entry_payload;
    logic [CNT_W-1:0]      length;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/olae_cell.sv
`default_nettype none

module olae_cell
  import olae_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  entry_t           lower,
  input  entry_t           upper,
  input  entry_t           load_val,
  input  logic [KEY_W-1:0] cmp_key,
  output entry_t           entry,
  output logic             match
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:       entry <= load_val;
      CELL_TAKE_LOWER: entry <= lower;
      CELL_TAKE_UPPER: entry <= upper;
      default:         entry <= entry;
    endcase
    if (ctl.cmp_en) begin
      match <= (entry.key == cmp_key);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ordered_array_list_engine_unit.sv
// Channel   Handshake          Payload
// command   start / busy       item   (item_t)
// result    done (one cycle)   result (result_t)
//
// A command is taken when start is high and busy is low; busy then stays high
// for one cycle, so commands cannot be taken back to back.
// The cells shift, load and compare keys at the accept edge; the next cycle
// picks the first match or the addressed cell, and done marks the result beat
// in the cycle after that. Synchronous reset empties the list; the receiver
// cannot stall the result.
`default_nettype none

module ordered_array_list_engine_unit
  import olae_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pend;
  cmd_e             s_cmd;
  status_e          s_status;
  logic [POS_W-1:0] s_pos;

  entry_t           entries [CAPACITY];
  logic [CAPACITY-1:0] match;
  cell_ctl_t        ctl [CAPACITY];
  entry_t           new_entry;

  status_e          status_now;
  logic [CNT_W-1:0] ipos;
  logic [CNT_W-1:0] pos_ext;
  logic             ins_ok;
  logic             del_ok;
  logic             upd_ok;

  result_t          res_next;
  logic             hit;
  logic [POS_W-1:0] hit_idx;
  entry_t           sel;
  logic [ITEM_PAY_W-1:0] sel_pay;

  assign accept = start && !busy;
  assign busy   = pend;

  assign new_entry.key     = item.item_key;
  assign new_entry.payload = item.item_payload[PAYLOAD_BITS-1:0];

  assign pos_ext = CNT_W'(item.position);
  assign ipos    = item.at_end ? count : pos_ext;

  always_comb begin
    status_now = ST_OK;
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    upd_ok     = 1'b0;
    count_next = count;
    case (cmd_e'(item.cmd))
      CMD_CLEAR: count_next = '0;
      CMD_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_now = ST_FULL;
        end else if (ipos > count) begin
          status_now = ST_BADPOS;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_ext >= count) begin
          status_now = ST_BADPOS;
        end else begin
          del_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_UPDATE, CMD_READ: begin
        if (pos_ext >= count) begin
          status_now = ST_BADPOS;
        end else begin
          upd_ok = (cmd_e'(item.cmd) == CMD_UPDATE);
        end
      end
      default: status_now = ST_OK;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].op     = CELL_HOLD;
      ctl[i].cmp_en = accept && (cmd_e'(item.cmd) == CMD_FIND);
      if (accept) begin
        if (ins_ok && CNT_W'(i) == ipos) begin
          ctl[i].op = CELL_LOAD;
        end else if (ins_ok && CNT_W'(i) > ipos) begin
          ctl[i].op = CELL_TAKE_LOWER;
        end else if (del_ok && CNT_W'(i) >= pos_ext && i < CAPACITY - 1) begin
          ctl[i].op = CELL_TAKE_UPPER;
        end else if (upd_ok && CNT_W'(i) == pos_ext) begin
          ctl[i].op = CELL_LOAD;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t lower_in;
    entry_t upper_in;
    if (g == 0) begin : g_first
      assign lower_in = '0;
    end else begin : g_mid_lo
      assign lower_in = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper_in = entries[g];
    end else begin : g_mid_hi
      assign upper_in = entries[g+1];
    end
    olae_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .lower    (lower_in),
      .upper    (upper_in),
      .load_val (new_entry),
      .cmp_key  (item.item_key),
      .entry    (entries[g]),
      .match    (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      pend <= accept;
      done <= pend;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd    <= cmd_e'(item.cmd);
      s_status <= status_now;
      s_pos    <= item.position;
    end
    if (pend) begin
      result <= res_next;
    end
  end

  // first matching valid cell
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i] && CNT_W'(i) < count) begin
        hit     = 1'b1;
        hit_idx = POS_W'(i);
      end
    end
  end

  always_comb begin
    sel = (s_cmd == CMD_FIND) ? entries[hit_idx] : entries[s_pos];
    sel_pay = '0;
    sel_pay[PAYLOAD_BITS-1:0] = sel.payload;
    res_next = '0;
    res_next.length = count;
    res_next.status = s_status;
    if (s_cmd == CMD_FIND) begin
      if (hit) begin
        res_next.found_position = hit_idx;
        res_next.entry_key      = sel.key;
        res_next.entry_payload  = sel_pay;
      end else begin
        res_next.status = ST_NOKEY;
      end
    end else if (s_cmd == CMD_READ && s_status == ST_OK) begin
      res_next.entry_key     = sel.key;
      res_next.entry_payload = sel_pay;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/olae_checker.sv
`default_nettype none

module olae_checker
  import olae_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result beat missing two cycles after accept");

  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in flight");

  a_nokey_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_NOKEY |->
      result.found_position == '0 && result.entry_key == '0 &&
      result.entry_payload == '0)
    else $error("missed find returns nonzero fields");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> result.length <= CNT_W'(CAPACITY))
    else $error("length beyond capacity");

endmodule

bind ordered_array_list_engine_unit olae_checker u_olae_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

`default_nettype wire
